// ===== rtl/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and fixed constants of the sliding window median core.
// ----------------------------------------------------------------------------
package swm_pkg;

    // fixed port widths
    localparam int SAMPLE_PORT_W = 32;
    localparam int MEDIAN_W      = 33;
    localparam int CFG_W         = 7;

    // window size after reset
    localparam int CFG_RESET     = 3;

    // per-cycle control handed to every cell of the row
    typedef struct packed {
        logic step;         // a sample transaction updates the row
        logic below;        // the leaving entry sits at a lower index
        logic at_or_below;  // the leaving entry sits at this index or lower
    } swm_ctl_t;

endpackage : swm_pkg
`default_nettype wire

// ===== rtl/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted row: holds a sample and its age, compares it with
// the incoming sample and takes its next contents from itself, a neighbor or
// the incoming sample.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int DATA_W = 32,
    parameter int AGE_W  = 6
) (
    input  wire                       clk,
    input  swm_pkg::swm_ctl_t         ctl,
    input  wire signed [DATA_W-1:0]   sample,
    input  wire                       valid,
    input  wire                       full,
    input  wire        [AGE_W-1:0]    last_age,
    input  wire signed [DATA_W-1:0]   lo_value,
    input  wire        [AGE_W-1:0]    lo_age,
    input  wire                       lo_le,
    input  wire signed [DATA_W-1:0]   hi_value,
    input  wire        [AGE_W-1:0]    hi_age,
    input  wire                       hi_le,
    output logic signed [DATA_W-1:0]  value,
    output logic        [AGE_W-1:0]   age,
    output logic                      le,
    output logic                      rem
);
    import swm_pkg::*;

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic        [AGE_W-1:0]  age_reg, age_next;
    logic signed [DATA_W-1:0] self_value, down_value;
    logic        [AGE_W-1:0]  self_age, down_age;
    logic                     self_le, down_le;

    // local compare and removal flags
    assign le  = valid && (value_reg <= sample);
    assign rem = full && valid && (age_reg == last_age);

    // view of the row after the leaving entry is squeezed out
    always_comb
    begin
        self_value = ctl.at_or_below ? hi_value : value_reg;
        self_age   = ctl.at_or_below ? hi_age   : age_reg;
        self_le    = ctl.at_or_below ? hi_le    : le;
        down_value = ctl.below ? value_reg : lo_value;
        down_age   = ctl.below ? age_reg   : lo_age;
        down_le    = ctl.below ? le        : lo_le;
    end

    // keep, take the new sample, or shift up from below
    always_comb
    begin
        if (self_le)
        begin
            value_next = self_value;
            age_next   = self_age + 1'b1;
        end
        else if (down_le)
        begin
            value_next = sample;
            age_next   = '0;
        end
        else
        begin
            value_next = down_value;
            age_next   = down_age + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            value_reg <= value_next;
            age_reg   <= age_next;
        end
    end

    assign value = value_reg;
    assign age   = age_reg;

endmodule : swm_cell
`default_nettype wire

// ===== rtl/sliding_window_median_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median_core
// Running median over the most recent window_size samples.
// ----------------------------------------------------------------------------
// The window is a row of WINDOW_MAX cells kept in ascending order; each cell
// holds one sample and its age. A sample transaction removes the oldest entry
// (once the window is full) and inserts the new one in the same row update, so
// the core takes one sample per cycle; a pending flag and then the result
// register hold the result, and a stalled result holds off further samples
// only while a second result is waiting. start_of_sequence or a write to
// window_size empties the window, and no result is given until window_size
// samples have arrived. median_twice is the median times two (sum of the two
// middle samples for an even window). window_size of zero acts as one, above
// WINDOW_MAX as WINDOW_MAX. Write window_size only while the core is idle.
// ----------------------------------------------------------------------------
module sliding_window_median_core #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    // configuration
    input  wire                                   window_size_we,
    input  wire        [swm_pkg::CFG_W-1:0]       window_size,
    // sample channel
    input  wire                                   sample_valid,
    output logic                                  sample_stall,
    input  wire signed [swm_pkg::SAMPLE_PORT_W-1:0] sample,
    input  wire                                   start_of_sequence,
    // median channel
    output logic                                  median_valid,
    input  wire                                   median_stall,
    output logic signed [swm_pkg::MEDIAN_W-1:0]   median_twice
);
    import swm_pkg::*;

    localparam int SIZE_W     = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int RESET_SIZE = (CFG_RESET > WINDOW_MAX) ? WINDOW_MAX : CFG_RESET;

    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;
    logic [SIZE_W-1:0] fill_eff;
    logic              pending_reg, pending_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [MEDIAN_W-1:0] median_reg, median_next;

    logic                          accept;
    logic                          out_free;
    logic                          full;
    logic                          produce;
    logic        [AGE_W-1:0]       last_age;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX];
    logic        [AGE_W-1:0]       cell_age   [WINDOW_MAX];
    logic        [WINDOW_MAX-1:0]  cell_le;
    logic        [WINDOW_MAX-1:0]  cell_rem;
    logic        [WINDOW_MAX-1:0]  cell_valid;
    logic        [WINDOW_MAX-1:0]  rem_below;
    logic        [WINDOW_MAX-1:0]  sel_hi;
    logic        [WINDOW_MAX-1:0]  sel_lo;

    logic signed [SAMPLE_BITS-1:0] mid_hi, mid_lo;
    logic signed [SAMPLE_BITS:0]   mid_sum;

    // handshake
    assign out_free     = !out_valid_reg || !median_stall;
    assign sample_stall = pending_reg && !out_free;
    assign accept       = sample_valid && !sample_stall;

    // window occupancy seen by this transaction
    assign sample_in = sample[SAMPLE_BITS-1:0];
    assign fill_eff  = start_of_sequence ? '0 : fill_reg;
    assign full      = (fill_eff >= size_reg);
    assign last_age  = AGE_W'(size_reg - 1'b1);
    assign fill_next = full ? fill_eff : fill_eff + 1'b1;
    assign produce   = (fill_next == size_reg);

    // per-cell occupancy and prefix of the leaving entry
    always_comb
    begin
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            cell_valid[i] = (SIZE_W'(i) < fill_eff);
            rem_below[i]  = |(cell_rem & ~({WINDOW_MAX{1'b1}} << i));
        end
    end

    // sorted row of cells
    for (genvar g = 0; g < WINDOW_MAX; g++)
    begin : g_cell
        swm_ctl_t                      ctl;
        logic signed [SAMPLE_BITS-1:0] lo_value, hi_value;
        logic        [AGE_W-1:0]       lo_age, hi_age;
        logic                          lo_le, hi_le;

        assign ctl.step        = accept;
        assign ctl.below       = rem_below[g];
        assign ctl.at_or_below = rem_below[g] | cell_rem[g];

        if (g == 0)
        begin : g_first
            assign lo_value = '0;
            assign lo_age   = '0;
            assign lo_le    = 1'b1;
        end
        else
        begin : g_mid_lo
            assign lo_value = cell_value[g-1];
            assign lo_age   = cell_age[g-1];
            assign lo_le    = cell_le[g-1];
        end

        if (g == WINDOW_MAX - 1)
        begin : g_last
            assign hi_value = '0;
            assign hi_age   = '0;
            assign hi_le    = 1'b0;
        end
        else
        begin : g_mid_hi
            assign hi_value = cell_value[g+1];
            assign hi_age   = cell_age[g+1];
            assign hi_le    = cell_le[g+1];
        end

        swm_cell #(
            .DATA_W (SAMPLE_BITS),
            .AGE_W  (AGE_W)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .sample   (sample_in),
            .valid    (cell_valid[g]),
            .full     (full),
            .last_age (last_age),
            .lo_value (lo_value),
            .lo_age   (lo_age),
            .lo_le    (lo_le),
            .hi_value (hi_value),
            .hi_age   (hi_age),
            .hi_le    (hi_le),
            .value    (cell_value[g]),
            .age      (cell_age[g]),
            .le       (cell_le[g]),
            .rem      (cell_rem[g])
        );
    end

    // middle taps, fixed while the window size holds
    always_comb
    begin
        mid_hi = '0;
        mid_lo = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            sel_hi[i] = (SIZE_W'(i) == (size_reg >> 1));
            sel_lo[i] = size_reg[0] ? sel_hi[i]
                                    : (SIZE_W'(i) == (size_reg >> 1) - 1'b1);
            mid_hi    = mid_hi | (sel_hi[i] ? cell_value[i] : '0);
            mid_lo    = mid_lo | (sel_lo[i] ? cell_value[i] : '0);
        end
        mid_sum = (SAMPLE_BITS + 1)'(mid_hi) + (SAMPLE_BITS + 1)'(mid_lo);
    end

    // effective window size on a configuration write
    always_comb
    begin
        if (window_size_we)
        begin
            if (window_size == '0)
                size_next = SIZE_W'(1);
            else if (int'(window_size) > WINDOW_MAX)
                size_next = SIZE_W'(WINDOW_MAX);
            else
                size_next = SIZE_W'(window_size);
        end
        else
        begin
            size_next = size_reg;
        end
    end

    // result register and pending flag
    always_comb
    begin
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        if (out_free)
        begin
            out_valid_next = pending_reg;
            pending_next   = 1'b0;
            if (pending_reg)
                median_next = MEDIAN_W'($unsigned(mid_sum));
        end
        if (accept && produce)
            pending_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_W'(RESET_SIZE);
            fill_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
            if (window_size_we)
                fill_reg <= '0;
            else if (accept)
                fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    assign median_valid = out_valid_reg;
    assign median_twice = median_reg;

    // assertions
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= size_reg)
        else $error("window fill exceeds window size");

    a_one_leaving: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_rem))
        else $error("more than one entry leaves the window");

    a_leaving_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |-> $onehot(cell_rem))
        else $error("full window has no oldest entry to drop");

    a_stays_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_of_sequence && !window_size_we && fill_reg == size_reg)
        |=> (fill_reg == $past(fill_reg)))
        else $error("full window lost an entry");

    a_pending_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && !out_free) |=> pending_reg)
        else $error("waiting result dropped under stall");

endmodule : sliding_window_median_core
`default_nettype wire
